### rtl/quadrature_position_velocity_core_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef QUADRATURE_POSITION_VELOCITY_CORE_MACROS_SVH
`define QUADRATURE_POSITION_VELOCITY_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QPV_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("qpv assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QPV_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("qpv assertion failed");

`endif

### rtl/qpv_pkg.sv
package qpv_pkg;

  localparam int unsigned FRACTION_BITS_DEF    = 16;
  localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;

  localparam int unsigned PULSES_PER_REV_DEFAULT = 3600;
  localparam int unsigned EDGES_PER_PULSE        = 2;
  localparam int unsigned EPR_W                  = 16;
  localparam logic [EPR_W-1:0] EPR_RESET =
    EPR_W'(PULSES_PER_REV_DEFAULT * EDGES_PER_PULSE);

  // Divisor width: edges per revolution times a 32-bit time step.
  localparam int unsigned DEN_W = EPR_W + 32;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGES_PER_REV = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_COUNT = 1'd1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_DT_ZERO = 2'd1;
  localparam logic [1:0] STATUS_VEL_SAT = 2'd2;

  typedef enum logic [1:0] {
    CMD_EDGE_A,
    CMD_EDGE_B,
    CMD_TICK,
    CMD_SET_REF
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MUL_N,
    S_MUL_D,
    S_DIV_VEL,
    S_REF,
    S_REF_WB,
    S_ANG_START,
    S_ANG_WAIT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    cmd_t               cmd;
    logic               level_a;
    logic               level_b;
    logic [31:0]        time_us;
    logic signed [31:0] new_angle;
  } item_t;

  typedef struct packed {
    logic signed [31:0] position_count;
    logic signed [31:0] angle;
    logic signed [31:0] velocity;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic start;
    logic neg;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic        sat;
    logic [31:0] quot;
  } div_rsp_t;

  function automatic logic [31:0] sat_limit(input logic neg);
    return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] p);
    return p[31] ? (32'd0 - p) : p;
  endfunction

  function automatic logic [31:0] apply_sign(input logic [31:0] m, input logic neg);
    return neg ? (32'd0 - m) : m;
  endfunction

endpackage

### rtl/qpv_div.sv
module qpv_div #(
  parameter int unsigned NUM_W = 68,
  parameter int unsigned DEN_W = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  qpv_pkg::div_req_t req,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output qpv_pkg::div_rsp_t rsp
);
  import qpv_pkg::*;

  `include "quadrature_position_velocity_core_macros.svh"

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [31:0]      q_r;
  logic             ovf_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [31:0]      lim;
  logic             over;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      neg_r <= req.neg;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_r   <= {q_r[30:0], ge};
      ovf_r <= ovf_r | q_r[31];
    end
  end

  assign lim  = sat_limit(neg_r);
  assign over = ovf_r || (q_r > lim);

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.sat  = over;
  assign rsp.quot = over ? lim : q_r;

  `QPV_ASSERT_IMP(a_no_start_busy, clk, rst_n, req.start, !busy_r && !done_r)
  `QPV_ASSERT_NXT(a_done_after_last, clk, rst_n, busy_r && cnt_r == CNT_W'(1), done_r && !busy_r)
  `QPV_ASSERT_IMP(a_sat_is_limit, clk, rst_n, done_r && over, rsp.quot == sat_limit(neg_r))

endmodule

### rtl/qpv_seq.sv
module qpv_seq #(
  parameter int unsigned FRACTION_BITS    = 16,
  parameter int unsigned TICKS_PER_SECOND = 1000000,
  parameter int unsigned NUM_W            = 68
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  qpv_pkg::item_t           item,
  input  logic [qpv_pkg::EPR_W-1:0] epr,
  input  logic                     invert,
  output logic                     res_valid,
  input  logic                     res_ready,
  output qpv_pkg::result_t         res
);
  import qpv_pkg::*;

  `include "quadrature_position_velocity_core_macros.svh"

  localparam int unsigned NMAG_W = NUM_W - FRACTION_BITS;

  seq_state_t state_r, state_nxt;

  cmd_t        cmd_r, cmd_nxt;
  logic        lvl_a_r, lvl_a_nxt;
  logic        lvl_b_r, lvl_b_nxt;
  logic [31:0] time_r, time_nxt;
  logic [31:0] na_r, na_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] dt_r, dt_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [31:0] edge_count_r, edge_count_nxt;
  logic [31:0] last_cnt_r, last_cnt_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic [31:0] vel_r, vel_nxt;
  logic [31:0] angle_r, angle_nxt;
  logic [1:0]  status_r, status_nxt;

  logic [EPR_W-1:0] epr_eff;
  logic [31:0]      tick_dt;
  logic [31:0]      tick_delta;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      product;
  logic [47:0]      ref_m;
  logic [47:0]      ref_lim;
  logic [47:0]      ref_clip;
  logic             up;

  div_req_t         div_req;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  div_rsp_t         div_rsp;

  assign epr_eff    = (epr == '0) ? EPR_W'(1) : epr;
  assign tick_dt    = time_r - last_time_r;
  assign tick_delta = edge_count_r - last_cnt_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL_N: begin
        mul_a = mag_r;
        mul_b = 32'(TICKS_PER_SECOND);
      end
      S_MUL_D: begin
        mul_a = dt_r;
        mul_b = 32'(epr_eff);
      end
      S_REF: begin
        mul_a = mag_r;
        mul_b = 32'(epr_eff);
      end
      default: begin
      end
    endcase
  end

  assign product = 64'(mul_a) * 64'(mul_b);

  assign ref_m    = prod_r[47:0] >> FRACTION_BITS;
  assign ref_lim  = 48'(sat_limit(neg_r));
  assign ref_clip = (ref_m > ref_lim) ? ref_lim : ref_m;

  always_comb begin
    up = lvl_a_r ^ lvl_b_r;
    if (cmd_r == CMD_EDGE_B) begin
      up = !up;
    end
    if (invert) begin
      up = !up;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r)
          CMD_EDGE_A, CMD_EDGE_B: state_nxt = S_ANG_START;
          CMD_TICK: state_nxt = (tick_dt == 32'd0) ? S_ANG_START : S_MUL_N;
          CMD_SET_REF: state_nxt = S_REF;
          default: state_nxt = S_ANG_START;
        endcase
      end
      S_MUL_N:     state_nxt = S_MUL_D;
      S_MUL_D:     state_nxt = S_DIV_VEL;
      S_DIV_VEL: begin
        if (div_rsp.done) begin
          state_nxt = S_ANG_START;
        end
      end
      S_REF:       state_nxt = S_REF_WB;
      S_REF_WB:    state_nxt = S_ANG_START;
      S_ANG_START: state_nxt = S_ANG_WAIT;
      S_ANG_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt        = cmd_r;
    lvl_a_nxt      = lvl_a_r;
    lvl_b_nxt      = lvl_b_r;
    time_nxt       = time_r;
    na_nxt         = na_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    dt_nxt         = dt_r;
    prod_nxt       = prod_r;
    edge_count_nxt = edge_count_r;
    last_cnt_nxt   = last_cnt_r;
    last_time_nxt  = last_time_r;
    vel_nxt        = vel_r;
    angle_nxt      = angle_r;
    status_nxt     = status_r;
    div_req        = '0;
    div_num        = '0;
    div_den        = '0;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt   = item.cmd;
          lvl_a_nxt = item.level_a;
          lvl_b_nxt = item.level_b;
          time_nxt  = item.time_us;
          na_nxt    = item.new_angle;
        end
      end
      S_EXEC: begin
        status_nxt = STATUS_OK;
        case (cmd_r)
          CMD_EDGE_A, CMD_EDGE_B: begin
            edge_count_nxt = up ? (edge_count_r + 32'd1) : (edge_count_r - 32'd1);
          end
          CMD_TICK: begin
            mag_nxt = mag32(tick_delta);
            neg_nxt = tick_delta[31];
            dt_nxt  = tick_dt;
            if (tick_dt == 32'd0) begin
              status_nxt = STATUS_DT_ZERO;
            end
          end
          CMD_SET_REF: begin
            mag_nxt = mag32(na_r);
            neg_nxt = na_r[31];
          end
          default: begin
          end
        endcase
      end
      S_MUL_N: begin
        prod_nxt = product;
      end
      S_MUL_D: begin
        div_req.start = 1'b1;
        div_req.neg   = neg_r;
        div_num       = NUM_W'({prod_r[NMAG_W-1:0], {FRACTION_BITS{1'b0}}});
        div_den       = product[DEN_W-1:0];
      end
      S_DIV_VEL: begin
        if (div_rsp.done) begin
          vel_nxt       = apply_sign(div_rsp.quot, neg_r);
          last_cnt_nxt  = edge_count_r;
          last_time_nxt = time_r;
          if (div_rsp.sat) begin
            status_nxt = STATUS_VEL_SAT;
          end
        end
      end
      S_REF: begin
        prod_nxt = product;
      end
      S_REF_WB: begin
        edge_count_nxt = apply_sign(ref_clip[31:0], neg_r);
      end
      S_ANG_START: begin
        div_req.start = 1'b1;
        div_req.neg   = edge_count_r[31];
        div_num       = NUM_W'({mag32(edge_count_r), {FRACTION_BITS{1'b0}}});
        div_den       = DEN_W'(epr_eff);
      end
      S_ANG_WAIT: begin
        if (div_rsp.done) begin
          angle_nxt = apply_sign(div_rsp.quot, edge_count_r[31]);
        end
      end
      S_DONE: begin
        res_valid = res_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      edge_count_r <= '0;
      last_cnt_r   <= '0;
      last_time_r  <= '0;
      vel_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      edge_count_r <= edge_count_nxt;
      last_cnt_r   <= last_cnt_nxt;
      last_time_r  <= last_time_nxt;
      vel_r        <= vel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    lvl_a_r  <= lvl_a_nxt;
    lvl_b_r  <= lvl_b_nxt;
    time_r   <= time_nxt;
    na_r     <= na_nxt;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    dt_r     <= dt_nxt;
    prod_r   <= prod_nxt;
    angle_r  <= angle_nxt;
    status_r <= status_nxt;
  end

  qpv_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .num   (div_num),
    .den   (div_den),
    .rsp   (div_rsp)
  );

  assign res.position_count = edge_count_r;
  assign res.angle          = angle_r;
  assign res.velocity       = vel_r;
  assign res.status         = status_r;

  `QPV_ASSERT_IMP(a_vel_wait_div, clk, rst_n, state_r == S_DIV_VEL, div_rsp.busy || div_rsp.done)
  `QPV_ASSERT_IMP(a_ang_wait_div, clk, rst_n, state_r == S_ANG_WAIT, div_rsp.busy || div_rsp.done)
  `QPV_ASSERT_IMP(a_idle_div_free, clk, rst_n, state_r == S_IDLE, !div_rsp.busy && !div_rsp.done)

endmodule

### rtl/quadrature_position_velocity_core.sv
// An edge beat or a zero-step tick runs one angle division; a velocity tick runs a velocity
// division first and set reference rescales the count first. The dividend is NUM_W bits, with
// NUM_W = 32 + clog2(TICKS_PER_SECOND + 1) + FRACTION_BITS (68 by default).
// One shared bit-serial divider; a new beat is taken only once the last result is handed on.
// Reset (rst_n low, synchronous) clears the count, samples and velocity, sets edges_per_rev
// to 7200 and count reversal off, and empties the output register.
module quadrature_position_velocity_core #(
  parameter int unsigned FRACTION_BITS    = qpv_pkg::FRACTION_BITS_DEF,
  parameter int unsigned TICKS_PER_SECOND = qpv_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // level_a, level_b, time_us, new_angle, zero fill
  input  logic [71:0]                  in_tdata,
  // cmd
  input  logic [1:0]                   in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // position_count, angle, velocity
  output logic [95:0]                  out_tdata,
  // status
  output logic [1:0]                   out_tuser,
  input  logic                         cfg_we,
  input  logic [qpv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qpv_pkg::EPR_W-1:0]     cfg_wdata
);
  import qpv_pkg::*;

  localparam int unsigned TPS_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned NUM_W = 32 + TPS_W + FRACTION_BITS;

  logic [EPR_W-1:0] epr_r;
  logic             invert_r;
  logic             out_valid_r;
  logic [95:0]      out_tdata_r;
  logic [1:0]       out_tuser_r;

  item_t   item;
  result_t res;
  logic    res_valid;
  logic    res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epr_r    <= EPR_RESET;
      invert_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EDGES_PER_REV: epr_r <= cfg_wdata;
        CFG_REVERSE_COUNT: invert_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign item.cmd       = cmd_t'(in_tuser[1:0]);
  assign item.level_a   = in_tdata[0];
  assign item.level_b   = in_tdata[1];
  assign item.time_us   = in_tdata[33:2];
  assign item.new_angle = in_tdata[65:34];

  assign res_ready = !out_valid_r || out_tready;

  qpv_seq #(
    .FRACTION_BITS    (FRACTION_BITS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .NUM_W            (NUM_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .item      (item),
    .epr       (epr_r),
    .invert    (invert_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_tdata_r <= {res.velocity, res.angle, res.position_count};
      out_tuser_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
